// File: sv/rfrt_pkg.sv
package rfrt_pkg;

  localparam int unsigned DefCordicSteps = 16;
  localparam int unsigned DefFracBits    = 16;
  localparam int unsigned TableLen       = 30;
  localparam int unsigned WordW          = 32;

  localparam logic signed [17:0] FullTurn    = 18'sd46080;
  localparam logic signed [17:0] HalfTurn    = 18'sd23040;
  localparam logic signed [17:0] QuarterTurn = 18'sd11520;
  localparam logic signed [33:0] CordicGain  = 34'sd652032874;
  // pi / 23040 in Q62, taken to Q30 by the shift after the multiply
  localparam logic [63:0] RadPerUnit = 64'hC90FDAA22168C234 / 64'd23040;

  typedef enum logic [2:0] {
    ActSetPos = 3'd0,
    ActRotX   = 3'd1,
    ActRotY   = 3'd2,
    ActRotZ   = 3'd3,
    ActFwd    = 3'd4,
    ActBack   = 3'd5,
    ActLeft   = 3'd6,
    ActRight  = 3'd7
  } action_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;       // capture input word
    logic       angle_prep; // reduce and fold angle
    logic       angle_scale;
    logic       cordic_init;
    logic       cordic_step;
    logic       trig_round;
    logic       mul_a;      // product phase
    logic       mul_b;      // sum, round, write
    logic [1:0] k;          // component index
  } rfrt_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } rfrt_sts_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sh3243F6A8;
      5'd1:  r = 34'sh1DAC6705;
      5'd2:  r = 34'sh0FADBAFC;
      5'd3:  r = 34'sh07F56EA6;
      5'd4:  r = 34'sh03FEAB76;
      5'd5:  r = 34'sh01FFD55B;
      5'd6:  r = 34'sh00FFFAAA;
      5'd7:  r = 34'sh007FFF55;
      5'd8:  r = 34'sh003FFFEA;
      5'd9:  r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF;
      5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;
      5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;
      5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;
      5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;
      5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF;
      5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF;
      5'd23: r = 34'sh0000007F;
      5'd24: r = 34'sh0000003F;
      5'd25: r = 34'sh0000001F;
      5'd26: r = 34'sh0000000F;
      5'd27: r = 34'sh00000008;
      5'd28: r = 34'sh00000004;
      5'd29: r = 34'sh00000002;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: sv/rfrt_ctrl.sv
module rfrt_ctrl #(
  parameter int unsigned CordicSteps = rfrt_pkg::DefCordicSteps
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          action_i,
  input  logic                out_busy_i,
  output logic                emit_o,
  output rfrt_pkg::rfrt_cmd_t cmd_o,
  input  rfrt_pkg::rfrt_sts_t sts_i
);
  import rfrt_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StPrep, StScale, StInit, StCordic, StRound,
    StMulA, StMulB, StMoveA, StMoveB, StEmit
  } state_e;

  state_e     state_q;
  logic [1:0] k_q;
  logic       rot_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.k           = k_q;
    cmd_o.load        = (state_q == StIdle) && in_valid_i && !out_busy_i;
    cmd_o.angle_prep  = (state_q == StPrep);
    cmd_o.angle_scale = (state_q == StScale);
    cmd_o.cordic_init = (state_q == StInit);
    cmd_o.cordic_step = (state_q == StCordic);
    cmd_o.trig_round  = (state_q == StRound);
    cmd_o.mul_a       = (state_q == StMulA) || (state_q == StMoveA);
    cmd_o.mul_b       = (state_q == StMulB) || (state_q == StMoveB);
  end

  assign in_ready_o = (state_q == StIdle) && !out_busy_i;
  assign emit_o     = (state_q == StEmit) && !out_busy_i;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= '0;
      rot_q   <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          k_q <= '0;
          if (in_valid_i && !out_busy_i) begin
            rot_q <= 1'b0;
            case (action_e'(action_i))
              ActSetPos: state_q <= StEmit;
              ActRotX, ActRotY, ActRotZ: begin
                rot_q   <= 1'b1;
                state_q <= StPrep;
              end
              default: state_q <= StMoveA;
            endcase
          end
        end
        StPrep:   state_q <= StScale;
        StScale:  state_q <= StInit;
        StInit:   state_q <= StCordic;
        StCordic: if (sts_i.cordic_done) state_q <= StRound;
        StRound:  state_q <= StMulA;
        StMulA:   state_q <= StMulB;
        StMoveA:  state_q <= StMoveB;
        StMulB, StMoveB: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd2) state_q <= StEmit;
          else state_q <= rot_q ? StMulA : StMoveA;
        end
        StEmit: if (!out_busy_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  a_step_only_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCordic) |-> rot_q) else $error("cordic on non rotation");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMulB) |-> (k_q != 2'd3)) else $error("component index");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !emit_o) else $error("ready while emitting");
  a_cordic_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == StCordic) |-> ##1 (state_q == StCordic || CordicSteps <= 1))
    else $error("cordic ended early");
endmodule

// File: sv/rfrt_datapath.sv
module rfrt_datapath #(
  parameter int unsigned CordicSteps = rfrt_pkg::DefCordicSteps,
  parameter int unsigned FracBits    = rfrt_pkg::DefFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfrt_pkg::rfrt_cmd_t cmd_i,
  output rfrt_pkg::rfrt_sts_t sts_o,
  input  logic [2:0]          action_i,
  input  logic signed [16:0]  angle_i,
  input  logic signed [31:0]  speed_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  output logic signed [31:0]  ent_o [12]
);
  import rfrt_pkg::*;

  localparam int unsigned Steps = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned TrigSh = 30 - FracBits;

  logic signed [31:0] ent_q [12];
  logic [2:0]         act_q;
  logic signed [16:0] angle_q;
  logic signed [31:0] speed_q;
  logic signed [17:0] r_q;
  logic               flip_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic [CntW-1:0]    i_q;
  logic signed [31:0] s_q, c_q;
  logic signed [63:0] p0_q, p1_q, p2_q, p3_q;

  assign ent_o = ent_q;
  assign sts_o.cordic_done = (i_q == CntW'(Steps - 1));

  // angle reduction and fold
  logic signed [17:0] r0, r1, r2;
  logic               fl;
  always_comb begin
    r0 = 18'(angle_q);
    if (r0 >= FullTurn) r0 = r0 - FullTurn;
    else if (r0 <= -FullTurn) r0 = r0 + FullTurn;
    if (r0 < 0) r0 = r0 + FullTurn;
    r1 = (r0 > HalfTurn) ? r0 - FullTurn : r0;
    fl = 1'b0;
    r2 = r1;
    if (r1 > QuarterTurn) begin
      r2 = HalfTurn - r1;
      fl = 1'b1;
    end else if (r1 < -QuarterTurn) begin
      r2 = -HalfTurn - r1;
      fl = 1'b1;
    end
  end

  // scale to radians, one 14x50 multiply
  logic [13:0]        mag;
  logic [77:0]        zprod;
  logic signed [33:0] zs;
  always_comb begin
    mag   = r_q[17] ? 14'(-r_q) : 14'(r_q);
    zprod = 78'(mag) * 78'(RadPerUnit);
    zs    = 34'(zprod[77:32]);
    if (r_q[17]) zs = -zs;
  end

  // one cordic step
  logic signed [33:0] xs, ys, xn, yn, zn;
  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    if (!z_q[33]) begin
      xn = x_q - ys; yn = y_q + xs; zn = z_q - atan_q30(5'(i_q));
    end else begin
      xn = x_q + ys; yn = y_q - xs; zn = z_q + atan_q30(5'(i_q));
    end
  end

  logic signed [33:0] sr, cr;
  always_comb begin
    sr = (y_q + (34'sd1 <<< (TrigSh - 1))) >>> TrigSh;
    cr = (x_q + (34'sd1 <<< (TrigSh - 1))) >>> TrigSh;
  end

  // operand selection for the shared multipliers
  logic [3:0] ia, ib;
  logic signed [31:0] va, vb, dmove;
  always_comb begin
    case (action_e'(act_q))
      ActRotX: begin ia = 4'(3 + cmd_i.k); ib = 4'(6 + cmd_i.k); end
      ActRotY: begin ia = 4'(6 + cmd_i.k); ib = 4'(0 + cmd_i.k); end
      ActRotZ: begin ia = 4'(0 + cmd_i.k); ib = 4'(3 + cmd_i.k); end
      ActFwd, ActBack: begin ia = 4'(6 + cmd_i.k); ib = 4'(9 + cmd_i.k); end
      default: begin ia = 4'(0 + cmd_i.k); ib = 4'(9 + cmd_i.k); end
    endcase
    va = ent_q[ia];
    vb = ent_q[ib];
    dmove = va;
  end

  logic               neg_mv;
  logic signed [65:0] suma, sumb, half;
  assign neg_mv = (act_q == ActBack) || (act_q == ActRight);
  always_comb begin
    half = 66'sd1 <<< (FracBits - 1);
    suma = ((66'(p0_q) + 66'(p1_q) + half) >>> FracBits);
    sumb = ((66'(p2_q) - 66'(p3_q) + half) >>> FracBits);
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 12; j++) begin
        ent_q[j] <= (j == 0 || j == 4 || j == 8) ? (32'sd1 <<< FracBits) : 32'sd0;
      end
      act_q   <= '0;
      angle_q <= '0;
      speed_q <= '0;
      r_q     <= '0;
      flip_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      s_q     <= '0;
      c_q     <= '0;
      p0_q    <= '0;
      p1_q    <= '0;
      p2_q    <= '0;
      p3_q    <= '0;
      i_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        act_q   <= action_i;
        angle_q <= angle_i;
        speed_q <= speed_i;
        if (action_i == ActSetPos) begin
          ent_q[9]  <= pos_x_i;
          ent_q[10] <= pos_y_i;
          ent_q[11] <= pos_z_i;
        end
      end
      if (cmd_i.angle_prep) begin
        r_q    <= r2;
        flip_q <= fl;
      end
      if (cmd_i.angle_scale) z_q <= zs;
      if (cmd_i.cordic_init) begin
        x_q <= CordicGain;
        y_q <= '0;
        i_q <= '0;
      end
      if (cmd_i.cordic_step) begin
        x_q <= xn;
        y_q <= yn;
        z_q <= zn;
        i_q <= i_q + CntW'(1);
      end
      if (cmd_i.trig_round) begin
        s_q <= 32'(sr);
        c_q <= flip_q ? -32'(cr) : 32'(cr);
      end
      if (cmd_i.mul_a) begin
        if (act_q[2]) begin
          p0_q <= 64'(neg_mv ? -64'(dmove) : 64'(dmove)) * 64'(speed_q);
        end else begin
          p0_q <= 64'(c_q) * 64'(va);
          p1_q <= 64'(s_q) * 64'(vb);
          p2_q <= 64'(c_q) * 64'(vb);
          p3_q <= 64'(s_q) * 64'(va);
        end
      end
      if (cmd_i.mul_b) begin
        if (act_q[2]) begin
          ent_q[ib] <= sat32(66'(vb) + ((66'(p0_q) + half) >>> FracBits));
        end else begin
          ent_q[ia] <= sat32(suma);
          ent_q[ib] <= sat32(sumb);
        end
      end
    end
  end
endmodule

// File: sv/rigid_frame_rotate_translate_unit.sv
// channel | handshake            | payload
// in      | in_valid_i/in_ready_o | action_i angle_i speed_i pos_x_i pos_y_i pos_z_i
// out     | out_valid_o/out_ready_i | column_o col_x_o col_y_o col_z_o last_o
// a rotation runs angle prep, the cordic loop, then three shared multiply
// passes; a move runs three multiply passes and set position none of them,
// before the four column words go out, one per accepted output word.
// reset loads the identity frame; no clearing pass.
// one item at a time: input is held off until the last column is taken.
module rigid_frame_rotate_translate_unit #(
  parameter int unsigned CORDIC_STEPS = rfrt_pkg::DefCordicSteps,
  parameter int unsigned FRAC_BITS    = rfrt_pkg::DefFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic signed [16:0] angle_i,
  input  logic signed [31:0] speed_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         column_o,
  output logic signed [31:0] col_x_o,
  output logic signed [31:0] col_y_o,
  output logic signed [31:0] col_z_o,
  output logic               last_o
);
  import rfrt_pkg::*;

  rfrt_cmd_t          cmd;
  rfrt_sts_t          sts;
  logic               emit;
  logic signed [31:0] ent [12];
  logic               busy_q;
  logic [1:0]         col_q;

  rfrt_ctrl #(.CordicSteps(CORDIC_STEPS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i,
    .out_busy_i(busy_q), .emit_o(emit), .cmd_o(cmd), .sts_i(sts)
  );

  rfrt_datapath #(.CordicSteps(CORDIC_STEPS), .FracBits(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .action_i, .angle_i, .speed_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .ent_o(ent)
  );

  // column streaming from the frame registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
    end else if (emit) begin
      busy_q <= 1'b1;
      col_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      col_q <= col_q + 2'd1;
      if (col_q == 2'd3) busy_q <= 1'b0;
    end
  end

  assign out_valid_o = busy_q;
  assign column_o    = col_q;
  assign col_x_o     = ent[{2'b00, col_q} * 4'd3];
  assign col_y_o     = ent[{2'b00, col_q} * 4'd3 + 4'd1];
  assign col_z_o     = ent[{2'b00, col_q} * 4'd3 + 4'd2];
  assign last_o      = (col_q == 2'd3);

  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o) else $error("input taken while streaming");
  a_first_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> (col_q == 2'd0)) else $error("stream start");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(last_o)) else $error("stream cut short");
endmodule

// File: sim/rigid_frame_rotate_translate_unit_test.sv
module rigid_frame_rotate_translate_unit_test;
  import rfrt_pkg::*;

  localparam int unsigned Steps = DefCordicSteps;
  localparam int unsigned Frac  = DefFracBits;
  localparam int          StallLimit = 20000;

  typedef struct packed {
    logic [1:0]         column;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic               last;
  } column_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         action_i = '0;
  logic signed [16:0] angle_i = '0;
  logic signed [31:0] speed_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         column_o;
  logic signed [31:0] col_x_o;
  logic signed [31:0] col_y_o;
  logic signed [31:0] col_z_o;
  logic               last_o;

  rigid_frame_rotate_translate_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .angle_i, .speed_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .out_valid_o, .out_ready_i, .column_o,
    .col_x_o, .col_y_o, .col_z_o, .last_o
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted frame and pending column words
  logic signed [31:0] frame_q [12];
  column_word_t       column_queue [$];
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  bit                 hold_off = 1'b0;
  int                 mismatches = 0;
  int                 words_seen = 0;
  int                 items_sent = 0;
  int                 idle_cycles = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_to(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint arctan_q30(int i);
    longint tbl [30] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
      'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
      'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
      'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
      'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F, 'h0000003F,
      'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};
    return tbl[i];
  endfunction

  // cordic sine and cosine of an angle in 1/128 degree
  task automatic trig_of_angle(input longint ang, output longint sn, output longint cs);
    longint r, x, y, z, nx;
    bit flip, neg;
    logic [127:0] wide;
    logic [63:0] per_unit;
    r = ang % 46080;
    flip = 0;
    per_unit = 64'hC90FDAA22168C234 / 64'd23040;
    if (r < 0) r += 46080;
    if (r > 23040) r -= 46080;
    if (r > 11520) begin
      r = 23040 - r;
      flip = 1;
    end else if (r < -11520) begin
      r = -23040 - r;
      flip = 1;
    end
    neg = r < 0;
    wide = 128'(neg ? -r : r) * 128'(per_unit);
    z = longint'(wide[63:32]);
    if (neg) z = -z;
    x = 652032874;
    y = 0;
    for (int i = 0; i < Steps && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= arctan_q30(i);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += arctan_q30(i);
      end
      x = nx;
    end
    sn = round_to(y, 30 - Frac);
    cs = round_to(x, 30 - Frac);
    if (flip) cs = -cs;
  endtask

  function automatic void rotate_columns(int a, int b, longint sn, longint cs);
    longint va, vb;
    for (int k = 0; k < 3; k++) begin
      va = frame_q[a*3+k];
      vb = frame_q[b*3+k];
      frame_q[a*3+k] = clamp32(round_to(cs*va + sn*vb, Frac));
      frame_q[b*3+k] = clamp32(round_to(cs*vb - sn*va, Frac));
    end
  endfunction

  function automatic void move_position(int axis, bit negate, longint spd);
    longint d;
    for (int k = 0; k < 3; k++) begin
      d = frame_q[axis*3+k];
      if (negate) d = -d;
      frame_q[9+k] = clamp32(longint'(frame_q[9+k]) + round_to(d*spd, Frac));
    end
  endfunction

  // apply one word to the predicted frame and queue the four columns
  task automatic predict_frame(input action_e act, input logic signed [16:0] ang,
                               input logic signed [31:0] spd, input logic signed [31:0] px,
                               input logic signed [31:0] py, input logic signed [31:0] pz);
    longint sn, cs;
    column_word_t w;
    case (act)
      ActSetPos: begin
        frame_q[9] = px; frame_q[10] = py; frame_q[11] = pz;
      end
      ActRotX: begin trig_of_angle(ang, sn, cs); rotate_columns(1, 2, sn, cs); end
      ActRotY: begin trig_of_angle(ang, sn, cs); rotate_columns(2, 0, sn, cs); end
      ActRotZ: begin trig_of_angle(ang, sn, cs); rotate_columns(0, 1, sn, cs); end
      ActFwd:   move_position(2, 1'b0, spd);
      ActBack:  move_position(2, 1'b1, spd);
      ActLeft:  move_position(0, 1'b0, spd);
      default:  move_position(0, 1'b1, spd);
    endcase
    for (int c = 0; c < 4; c++) begin
      w.column = c[1:0];
      w.cx = frame_q[c*3];
      w.cy = frame_q[c*3+1];
      w.cz = frame_q[c*3+2];
      w.last = (c == 3);
      column_queue.push_back(w);
    end
  endtask

  // send one word and predict its columns; valid drops only while idling
  task automatic send_word(input action_e act, input logic signed [16:0] ang,
                           input logic signed [31:0] spd, input logic signed [31:0] px,
                           input logic signed [31:0] py, input logic signed [31:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act; angle_i <= ang; speed_i <= spd;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_frame(act, ang, spd, px, py, pz);
    items_sent++;
  endtask

  // receiver ready
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // column checker and watchdog
  always @(posedge clk_i) begin
    column_word_t exp_w;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        words_seen++;
        if (column_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected column word %0d", column_o);
        end else begin
          exp_w = column_queue.pop_front();
          if (exp_w.column !== column_o || exp_w.cx !== col_x_o || exp_w.cy !== col_y_o ||
              exp_w.cz !== col_z_o || exp_w.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp col %0d (%0d %0d %0d) last %0d got col %0d (%0d %0d %0d) last %0d",
                       exp_w.column, exp_w.cx, exp_w.cy, exp_w.cz, exp_w.last,
                       column_o, col_x_o, col_y_o, col_z_o, last_o);
          end
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no progress");
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 'h60000)) - 'sh30000;
    endcase
  endfunction

  function automatic logic signed [16:0] rand_angle();
    if ($urandom_range(3) == 0) return $signed(17'($urandom));
    return 17'($signed($urandom_range(0, 92160)) - 46080);
  endfunction

  task automatic test_extremes();
    send_word(ActSetPos, '0, '0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000);
    send_word(ActFwd, '0, 32'sh7FFFFFFF, '0, '0, '0);
    send_word(ActBack, '0, 32'sh80000000, '0, '0, '0);
    send_word(ActLeft, 17'sh0FFFF, 32'sh00028000, '1, '1, '1);
    send_word(ActRight, '0, -32'sh00018000, '0, '0, '0);
    send_word(ActSetPos, '0, '0, '0, '0, '0);
  endtask

  task automatic test_rotations();
    // quarter turns, half turn, folds, wraps and the field extremes
    logic signed [16:0] angs [8] = '{17'sd11520, -17'sd11520, 17'sd23040, 17'sd46080,
                                     -17'sd46080, 17'sd65535, -17'sd65536, 17'sd3840};
    for (int i = 0; i < 8; i++) send_word(action_e'(1 + i % 3), angs[i], '1, '0, '0, '0);
    send_word(ActRotX, 17'sd12000, '0, '0, '0, '0);
    send_word(ActRotZ, -17'sd30000, '0, '0, '0, '0);
    send_word(ActFwd, '0, 32'sh00050000, '0, '0, '0);
    send_word(ActRight, '0, 32'sh00030000, '0, '0, '0);
  endtask

  task automatic test_random(input int n);
    action_e act;
    for (int i = 0; i < n; i++) begin
      act = action_e'($urandom_range(7));
      send_word(act, rand_angle(), rand_word(), $urandom, rand_word(), rand_word());
    end
  endtask

  // block fills up while the receiver is held off
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(6);
    join
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (column_queue.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    frame_q = '{default: 0};
    frame_q[0] = 1 << Frac; frame_q[4] = 1 << Frac; frame_q[8] = 1 << Frac;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_rotations();
    send_idle_pct = 15; recv_idle_pct = 59;
    test_random(165);
    send_idle_pct = 59; recv_idle_pct = 15;
    test_random(165);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(160);
    drain();
    repeat (50) @(posedge clk_i);
    $display("sent %0d words over all actions, checked %0d column words, %0d mismatches",
             items_sent, words_seen, mismatches);
    if (mismatches == 0 && column_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
